[src/atss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atss_pkg: shared types and constants of the alias table sampler
// Widths, command and status codes, and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package atss_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int FRAC_BITS   = 16;
  localparam int W_W         = 17;
  localparam int SC_W        = 23;
  localparam int RND_W       = 16;
  localparam int CMD_W       = 2;
  localparam int STS_W       = 2;
  localparam int PROD_W      = RND_W + CNT_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [SC_W-1:0]  ONE_SC  = SC_W'(1) << FRAC_BITS;
  localparam logic [W_W-1:0]   ONE_KP  = W_W'(1) << FRAC_BITS;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  // result status
  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STS_W-1:0] ST_NOT_BUILT = 2'd2;

  typedef enum logic [2:0] {
    K_LOAD,
    K_BUILD,
    K_SAMPLE,
    K_EMPTY,
    K_NOP
  } kind_e;

  // classified transaction waiting for the back end
  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] idx;
    logic [W_W-1:0]   weight;
    logic [RND_W-1:0] coin;
  } qent_t;

  // queue status seen by the front and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } qsts_t;

endpackage
`default_nettype wire

[src/atss_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atss_if: request and response channels of the alias table sampler
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface atss_in_if;
  logic                         valid;
  logic                         ready;
  logic [atss_pkg::CMD_W-1:0]   command;
  logic [atss_pkg::IDX_W-1:0]   entry_index;
  logic [atss_pkg::W_W-1:0]     weight;
  logic [atss_pkg::RND_W-1:0]   rand_bin;
  logic [atss_pkg::RND_W-1:0]   rand_coin;

  modport source (output valid, command, entry_index, weight, rand_bin, rand_coin,
                  input ready);
  modport sink (input valid, command, entry_index, weight, rand_bin, rand_coin,
                output ready);
endinterface

interface atss_out_if;
  logic                         valid;
  logic                         ready;
  logic [atss_pkg::IDX_W-1:0]   chosen_index;
  logic [atss_pkg::STS_W-1:0]   status;

  modport source (output valid, chosen_index, status, input ready);
  modport sink (input valid, chosen_index, status, output ready);
endinterface
`default_nettype wire

[src/atss_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atss_front: request intake and classification
// Decodes each request, settles the empty-table case and computes the bin.
// ----------------------------------------------------------------------------
module atss_front (
  atss_in_if.sink                  req_i,
  input  wire logic [atss_pkg::CNT_W-1:0] n_i,
  input  wire atss_pkg::qsts_t     qsts_i,
  output logic                     push_o,
  output atss_pkg::qent_t          ent_o
);

  logic [atss_pkg::PROD_W-1:0] prod;
  logic [atss_pkg::CNT_W-1:0]  bin_raw;
  logic [atss_pkg::CNT_W-1:0]  bin;

  // accept whenever the queue has room
  assign req_i.ready = !qsts_i.full;
  assign push_o      = req_i.valid && !qsts_i.full;

  // bin = (rand_bin * n) >> FRAC_BITS, clamped to n-1
  assign prod    = atss_pkg::PROD_W'(req_i.rand_bin) * atss_pkg::PROD_W'(n_i);
  assign bin_raw = prod[atss_pkg::PROD_W-1:atss_pkg::FRAC_BITS];
  assign bin     = (bin_raw >= n_i) ? (n_i - 1'b1) : bin_raw;

  // classify the transaction
  always_comb begin
    ent_o.idx    = req_i.entry_index;
    ent_o.weight = req_i.weight;
    ent_o.coin   = req_i.rand_coin;
    unique case (req_i.command)
      atss_pkg::CMD_LOAD: begin
        ent_o.kind = atss_pkg::K_LOAD;
      end
      atss_pkg::CMD_BUILD: begin
        ent_o.kind = (n_i == '0) ? atss_pkg::K_EMPTY : atss_pkg::K_BUILD;
      end
      atss_pkg::CMD_SAMPLE: begin
        ent_o.kind = (n_i == '0) ? atss_pkg::K_EMPTY : atss_pkg::K_SAMPLE;
        ent_o.idx  = bin[atss_pkg::IDX_W-1:0];
      end
      default: begin
        ent_o.kind = atss_pkg::K_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/atss_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atss_queue: two-entry queue between front and back end
// Lets the intake and the table sequencer stall independently.
// ----------------------------------------------------------------------------
module atss_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire atss_pkg::qent_t din_i,
  input  wire logic            pop_i,
  output atss_pkg::qent_t      dout_o,
  output atss_pkg::qsts_t      qsts_o
);

  atss_pkg::qent_t mem_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign dout_o       = mem_q[rptr_q];
  assign qsts_o.full  = (cnt_q == 2'd2);
  assign qsts_o.empty = (cnt_q == 2'd0);

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = !wptr_q;
    end
    if (pop_i) begin
      rptr_d = !rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

endmodule
`default_nettype wire

[src/atss_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atss_back: table sequencer and sampler
// Holds the weight, work, probability, alias and stack memories, builds the
// alias table one step per state and answers samples from it.
// ----------------------------------------------------------------------------
module atss_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [atss_pkg::CNT_W-1:0] n_i,
  input  wire logic                       cfg_we_i,
  input  wire atss_pkg::qsts_t            qsts_i,
  input  wire atss_pkg::qent_t            head_i,
  output logic                            pop_o,
  atss_out_if.source                      rsp_o
);

  localparam int IW = atss_pkg::IDX_W;
  localparam int CW = atss_pkg::CNT_W;
  localparam int SW = atss_pkg::SC_W;
  localparam int WW = atss_pkg::W_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SMP    = 4'd1;
  localparam logic [3:0] S_SC_RD  = 4'd2;
  localparam logic [3:0] S_SC_WR  = 4'd3;
  localparam logic [3:0] S_PR_POP = 4'd4;
  localparam logic [3:0] S_PR_RD  = 4'd5;
  localparam logic [3:0] S_PR_WR  = 4'd6;
  localparam logic [3:0] S_LG_POP = 4'd7;
  localparam logic [3:0] S_LG_WR  = 4'd8;
  localparam logic [3:0] S_SM_POP = 4'd9;
  localparam logic [3:0] S_SM_WR  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  // memories
  logic [WW-1:0] wt_mem [atss_pkg::MAX_ENTRIES];
  logic [SW-1:0] sc_mem [atss_pkg::MAX_ENTRIES];
  logic [WW-1:0] kp_mem [atss_pkg::MAX_ENTRIES];
  logic [IW-1:0] al_mem [atss_pkg::MAX_ENTRIES];
  logic [IW-1:0] ss_mem [atss_pkg::MAX_ENTRIES];
  logic [IW-1:0] ls_mem [atss_pkg::MAX_ENTRIES];

  // registered read data
  logic [WW-1:0] wt_rd_q;
  logic [SW-1:0] sca_rd_q, scb_rd_q;
  logic [WW-1:0] kp_rd_q;
  logic [IW-1:0] al_rd_q;
  logic [IW-1:0] ss_rd_q, ls_rd_q;

  // memory port controls
  logic          wt_we, wt_re;
  logic [IW-1:0] wt_wa, wt_ra;
  logic          sc_we, sc_re;
  logic [IW-1:0] sc_wa, sca_ra, scb_ra;
  logic [SW-1:0] sc_wd;
  logic          kp_we, kp_re;
  logic [IW-1:0] kp_wa, kp_ra;
  logic [WW-1:0] kp_wd;
  logic [IW-1:0] al_wd;
  logic          ss_we, ss_re, ls_we, ls_re;
  logic [IW-1:0] ss_wa, ss_ra, ls_wa, ls_ra, stk_wd;

  // control state
  logic [3:0]              state_q, state_d;
  logic [CW-1:0]           i_q, i_d;
  logic [CW-1:0]           stop_q, stop_d;
  logic [CW-1:0]           ltop_q, ltop_d;
  logic                    built_q, built_d;
  logic [IW-1:0]           bin_q, bin_d;
  logic [atss_pkg::RND_W-1:0] coin_q, coin_d;
  logic                    out_vld_q, out_vld_d;
  logic [IW-1:0]           out_idx_q, out_idx_d;
  logic [atss_pkg::STS_W-1:0] out_sts_q, out_sts_d;

  logic          out_free;
  logic [SW+CW-1:0] sc_prod;
  logic [SW-1:0] sc_new;
  logic [SW-1:0] pair_sum;

  assign out_free         = !out_vld_q || rsp_o.ready;
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.chosen_index = out_idx_q;
  assign rsp_o.status       = out_sts_q;

  assign sc_prod  = (SW + CW)'(wt_rd_q) * (SW + CW)'(n_i);
  assign sc_new   = sc_prod[SW-1:0];
  assign pair_sum = scb_rd_q + sca_rd_q - atss_pkg::ONE_SC;

  // sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    stop_d    = stop_q;
    ltop_d    = ltop_q;
    built_d   = built_q;
    bin_d     = bin_q;
    coin_d    = coin_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_idx_d = out_idx_q;
    out_sts_d = out_sts_q;
    pop_o     = 1'b0;
    wt_we = 1'b0; wt_wa = head_i.idx; wt_re = 1'b0; wt_ra = i_q[IW-1:0];
    sc_we = 1'b0; sc_wa = i_q[IW-1:0]; sc_wd = sc_new; sc_re = 1'b0;
    sca_ra = ss_rd_q; scb_ra = ls_rd_q;
    kp_we = 1'b0; kp_wa = ss_rd_q; kp_wd = sca_rd_q[WW-1:0]; al_wd = ls_rd_q;
    kp_re = 1'b0; kp_ra = head_i.idx;
    ss_we = 1'b0; ss_wa = stop_q[IW-1:0]; ss_re = 1'b0; ss_ra = IW'(stop_q - 1'b1);
    ls_we = 1'b0; ls_wa = ltop_q[IW-1:0]; ls_re = 1'b0; ls_ra = IW'(ltop_q - 1'b1);
    stk_wd = i_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (!qsts_i.empty) begin
          case (head_i.kind)
            atss_pkg::K_BUILD: begin
              pop_o   = 1'b1;
              i_d     = '0;
              stop_d  = '0;
              ltop_d  = '0;
              state_d = S_SC_RD;
            end
            atss_pkg::K_SAMPLE: begin
              if (built_q) begin
                pop_o   = 1'b1;
                kp_re   = 1'b1;
                bin_d   = head_i.idx;
                coin_d  = head_i.coin;
                state_d = S_SMP;
              end else if (out_free) begin
                pop_o     = 1'b1;
                out_vld_d = 1'b1;
                out_idx_d = '0;
                out_sts_d = atss_pkg::ST_NOT_BUILT;
              end
            end
            default: begin
              if (out_free) begin
                pop_o     = 1'b1;
                out_vld_d = 1'b1;
                out_idx_d = '0;
                out_sts_d = (head_i.kind == atss_pkg::K_EMPTY) ?
                            atss_pkg::ST_EMPTY : atss_pkg::ST_OK;
                if (head_i.kind == atss_pkg::K_LOAD) begin
                  wt_we   = 1'b1;
                  built_d = 1'b0;
                end
              end
            end
          endcase
        end
      end
      S_SMP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_sts_d = atss_pkg::ST_OK;
          out_idx_d = ({1'b0, coin_q} < kp_rd_q) ? bin_q : al_rd_q;
          state_d   = S_IDLE;
        end
      end
      // scale each weight by n and sort into the two stacks
      S_SC_RD: begin
        wt_re   = 1'b1;
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        sc_we = 1'b1;
        if (sc_new < atss_pkg::ONE_SC) begin
          ss_we  = 1'b1;
          stop_d = stop_q + 1'b1;
        end else begin
          ls_we  = 1'b1;
          ltop_d = ltop_q + 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 == n_i) ? S_PR_POP : S_SC_RD;
      end
      // pair the top small entry with the top large entry
      S_PR_POP: begin
        if (stop_q != '0 && ltop_q != '0) begin
          ss_re   = 1'b1;
          ls_re   = 1'b1;
          stop_d  = stop_q - 1'b1;
          ltop_d  = ltop_q - 1'b1;
          state_d = S_PR_RD;
        end else begin
          state_d = S_LG_POP;
        end
      end
      S_PR_RD: begin
        sc_re   = 1'b1;
        state_d = S_PR_WR;
      end
      S_PR_WR: begin
        kp_we  = 1'b1;
        sc_we  = 1'b1;
        sc_wa  = ls_rd_q;
        sc_wd  = pair_sum;
        stk_wd = ls_rd_q;
        if (pair_sum < atss_pkg::ONE_SC) begin
          ss_we  = 1'b1;
          stop_d = stop_q + 1'b1;
        end else begin
          ls_we  = 1'b1;
          ltop_d = ltop_q + 1'b1;
        end
        state_d = S_PR_POP;
      end
      // leftover entries keep themselves
      S_LG_POP: begin
        if (ltop_q != '0) begin
          ls_re   = 1'b1;
          ltop_d  = ltop_q - 1'b1;
          state_d = S_LG_WR;
        end else begin
          state_d = S_SM_POP;
        end
      end
      S_LG_WR: begin
        kp_we   = 1'b1;
        kp_wa   = ls_rd_q;
        kp_wd   = atss_pkg::ONE_KP;
        al_wd   = ls_rd_q;
        state_d = S_LG_POP;
      end
      S_SM_POP: begin
        if (stop_q != '0) begin
          ss_re   = 1'b1;
          stop_d  = stop_q - 1'b1;
          state_d = S_SM_WR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SM_WR: begin
        kp_we   = 1'b1;
        kp_wa   = ss_rd_q;
        kp_wd   = atss_pkg::ONE_KP;
        al_wd   = ss_rd_q;
        state_d = S_SM_POP;
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_idx_d = '0;
          out_sts_d = atss_pkg::ST_OK;
          built_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a count rewrite invalidates the table
    if (cfg_we_i) begin
      built_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      stop_q    <= '0;
      ltop_q    <= '0;
      built_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      stop_q    <= stop_d;
      ltop_q    <= ltop_d;
      built_q   <= built_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    coin_q    <= coin_d;
    out_idx_q <= out_idx_d;
    out_sts_q <= out_sts_d;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= head_i.weight;
    end
    if (wt_re) begin
      wt_rd_q <= wt_mem[wt_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      sc_mem[sc_wa] <= sc_wd;
    end
    if (sc_re) begin
      sca_rd_q <= sc_mem[sca_ra];
      scb_rd_q <= sc_mem[scb_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kp_we) begin
      kp_mem[kp_wa] <= kp_wd;
      al_mem[kp_wa] <= al_wd;
    end
    if (kp_re) begin
      kp_rd_q <= kp_mem[kp_ra];
      al_rd_q <= al_mem[kp_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ss_we) begin
      ss_mem[ss_wa] <= stk_wd;
    end
    if (ss_re) begin
      ss_rd_q <= ss_mem[ss_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[ls_wa] <= stk_wd;
    end
    if (ls_re) begin
      ls_rd_q <= ls_mem[ls_ra];
    end
  end

endmodule
`default_nettype wire

[src/alias_table_sampler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alias_table_sampler_unit: Walker alias sampler, Q.16 fixed point
// Loads weights, builds the alias table and draws samples from it.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_i    | in        | command, entry_index, weight, rand_bin, rand_coin
//  rsp_o    | out       | chosen_index, status (one per request)
//  cfg      | in        | cfg_we_i / cfg_wdata_i: entry_count
//
//  load, status-only and not-built results: answered from the idle state of the sequencer
//  sample: bin multiply in the intake, then probability/alias read and compare in the sequencer
//  build: the sequencer walks the memories for n entries: read and write per scaled entry,
//  pop, read and write per pairing, pop and write per leftover entry; no requests leave the
//  queue meanwhile
//  reset clears control state only; the memories hold garbage until written
//  a stalled result holds in the output register while up to two requests queue
// ----------------------------------------------------------------------------
module alias_table_sampler_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [atss_pkg::CNT_W-1:0] cfg_wdata_i,
  atss_in_if.sink                         req_i,
  atss_out_if.source                      rsp_o
);

  logic [atss_pkg::CNT_W-1:0] cnt_q;
  logic [atss_pkg::CNT_W-1:0] n;
  logic                       push;
  logic                       pop;
  atss_pkg::qent_t            ent;
  atss_pkg::qent_t            head;
  atss_pkg::qsts_t            qsts;

  // entry count register, clamped to capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  assign n = (cnt_q > atss_pkg::MAX_CNT) ? atss_pkg::MAX_CNT : cnt_q;

  atss_front u_front (
    .req_i  (req_i),
    .n_i    (n),
    .qsts_i (qsts),
    .push_o (push),
    .ent_o  (ent)
  );

  atss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (ent),
    .pop_i  (pop),
    .dout_o (head),
    .qsts_o (qsts)
  );

  atss_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .n_i      (n),
    .cfg_we_i (cfg_we_i),
    .qsts_i   (qsts),
    .head_i   (head),
    .pop_o    (pop),
    .rsp_o    (rsp_o)
  );

endmodule
`default_nettype wire

[src/atss_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atss_checker: port-level checks of the alias table sampler
// Watches the result channel against the programmed entry count.
// ----------------------------------------------------------------------------
module atss_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        cfg_we_i,
  input wire logic [atss_pkg::CNT_W-1:0]  cfg_wdata_i,
  input wire logic                        rsp_valid_i,
  input wire logic                        rsp_ready_i,
  input wire logic [atss_pkg::IDX_W-1:0]  chosen_i,
  input wire logic [atss_pkg::STS_W-1:0]  status_i
);

  logic [atss_pkg::CNT_W-1:0] cnt_q;
  logic [atss_pkg::CNT_W-1:0] lim;

  // shadow of the entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  assign lim = (cnt_q > atss_pkg::MAX_CNT) ? atss_pkg::MAX_CNT : cnt_q;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(chosen_i) && $stable(status_i))
    else $error("result changed while stalled");

  // only defined status codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == atss_pkg::ST_OK || status_i == atss_pkg::ST_EMPTY ||
                     status_i == atss_pkg::ST_NOT_BUILT))
    else $error("undefined status");

  // error results carry index zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != atss_pkg::ST_OK |-> chosen_i == '0)
    else $error("error result with nonzero index");

  // empty status only with no entries
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == atss_pkg::ST_EMPTY |-> cnt_q == '0)
    else $error("empty status with entries in use");

  // sampled index within the table
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == atss_pkg::ST_OK && cnt_q != '0 |->
      atss_pkg::CNT_W'(chosen_i) < lim)
    else $error("index beyond entry count");

endmodule

bind alias_table_sampler_unit atss_checker u_atss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .chosen_i    (rsp_o.chosen_index),
  .status_i    (rsp_o.status)
);
`default_nettype wire
